// ===== design/lfo_pkg.sv =====
// Package for the low-frequency oscillator: widths, rate constants, waveform codes, sine table.
`default_nettype none

package lfo_pkg;

    localparam int COUNT_WIDTH = 16;

    localparam logic [14:0] RATE_BASE  = 15'd31254;
    localparam logic [14:0] RATE_SLOPE = 15'd119;
    localparam logic [7:0]  TRI_PEAK   = 8'h7F;

    typedef enum logic [1:0] {
        WAVE_SINE = 2'd0,
        WAVE_SAW  = 2'd1,
        WAVE_TRI  = 2'd2
    } wave_code_t;

    typedef logic [COUNT_WIDTH-1:0] count_t;

    // One period of sine scaled to 0..254 around 127; the last entry is pinned to 127.
    localparam logic [7:0] SINE_TABLE [256] = '{
        8'd127, 8'd130, 8'd133, 8'd136, 8'd139, 8'd142, 8'd145, 8'd148,
        8'd151, 8'd154, 8'd157, 8'd160, 8'd163, 8'd166, 8'd169, 8'd172,
        8'd175, 8'd178, 8'd181, 8'd184, 8'd186, 8'd189, 8'd192, 8'd194,
        8'd197, 8'd200, 8'd202, 8'd205, 8'd207, 8'd209, 8'd212, 8'd214,
        8'd216, 8'd218, 8'd221, 8'd223, 8'd225, 8'd227, 8'd229, 8'd230,
        8'd232, 8'd234, 8'd235, 8'd237, 8'd239, 8'd240, 8'd241, 8'd243,
        8'd244, 8'd245, 8'd246, 8'd247, 8'd248, 8'd249, 8'd250, 8'd250,
        8'd251, 8'd252, 8'd252, 8'd253, 8'd253, 8'd253, 8'd253, 8'd253,
        8'd254, 8'd253, 8'd253, 8'd253, 8'd253, 8'd253, 8'd252, 8'd252,
        8'd251, 8'd250, 8'd250, 8'd249, 8'd248, 8'd247, 8'd246, 8'd245,
        8'd244, 8'd243, 8'd241, 8'd240, 8'd239, 8'd237, 8'd235, 8'd234,
        8'd232, 8'd230, 8'd229, 8'd227, 8'd225, 8'd223, 8'd221, 8'd218,
        8'd216, 8'd214, 8'd212, 8'd209, 8'd207, 8'd205, 8'd202, 8'd200,
        8'd197, 8'd194, 8'd192, 8'd189, 8'd186, 8'd184, 8'd181, 8'd178,
        8'd175, 8'd172, 8'd169, 8'd166, 8'd163, 8'd160, 8'd157, 8'd154,
        8'd151, 8'd148, 8'd145, 8'd142, 8'd139, 8'd136, 8'd133, 8'd130,
        8'd127, 8'd123, 8'd120, 8'd117, 8'd114, 8'd111, 8'd108, 8'd105,
        8'd102, 8'd99,  8'd96,  8'd93,  8'd90,  8'd87,  8'd84,  8'd81,
        8'd78,  8'd75,  8'd72,  8'd69,  8'd67,  8'd64,  8'd61,  8'd59,
        8'd56,  8'd53,  8'd51,  8'd48,  8'd46,  8'd44,  8'd41,  8'd39,
        8'd37,  8'd35,  8'd32,  8'd30,  8'd28,  8'd26,  8'd24,  8'd23,
        8'd21,  8'd19,  8'd18,  8'd16,  8'd14,  8'd13,  8'd12,  8'd10,
        8'd9,   8'd8,   8'd7,   8'd6,   8'd5,   8'd4,   8'd3,   8'd3,
        8'd2,   8'd1,   8'd1,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   8'd1,
        8'd2,   8'd3,   8'd3,   8'd4,   8'd5,   8'd6,   8'd7,   8'd8,
        8'd9,   8'd10,  8'd12,  8'd13,  8'd14,  8'd16,  8'd18,  8'd19,
        8'd21,  8'd23,  8'd24,  8'd26,  8'd28,  8'd30,  8'd32,  8'd35,
        8'd37,  8'd39,  8'd41,  8'd44,  8'd46,  8'd48,  8'd51,  8'd53,
        8'd56,  8'd59,  8'd61,  8'd64,  8'd67,  8'd69,  8'd72,  8'd75,
        8'd78,  8'd81,  8'd84,  8'd87,  8'd90,  8'd93,  8'd96,  8'd99,
        8'd102, 8'd105, 8'd108, 8'd111, 8'd114, 8'd117, 8'd120, 8'd127
    };

endpackage

`default_nettype wire

// ===== design/lfo_waveform_generator_unit.sv =====
// Top level of the low-frequency oscillator: tick counter, phase, sine ROM and level stage.
`default_nettype none

// Each accepted input word is one timer tick and yields exactly one output word.
// The block takes a word in every clock cycle. A word is registered in the middle
// stage as it is accepted and then in the output register. On acceptance the counter
// is compared, the phase is advanced on a match and the synchronous sine ROM is read
// at the new phase. As the middle stage moves on, a word that stepped the phase forms
// the level from that ROM word or from the phase; other words repeat the held level.
// A stalled output register holds the middle stage, and the input is then taken only
// when that stage moves on. A valid knob reading with a tick sets the compare value
// from the next tick on. Reset is asynchronous and clears the counter, the compare
// value, the phase and the held level; the first tick then advances the phase.
module lfo_waveform_generator_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       knob_valid,
    input  wire logic [7:0] knob_level,
    input  wire logic [1:0] wave_choice,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_level,
    output logic            phase_step,
    output logic [7:0]      phase_now
);
    import lfo_pkg::*;

    count_t      tick_count_reg, tick_count_next;
    count_t      compare_reg, compare_next;
    logic [7:0]  phase_reg, phase_next;
    logic [7:0]  level_hold_reg, level_hold_next;

    logic        s1_valid_reg, s1_valid_next;
    logic        s1_stepped_reg;
    logic [7:0]  s1_phase_reg;
    wave_code_t  s1_choice_reg;
    logic [7:0]  rom_data_reg;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_level_reg;
    logic        out_step_reg;
    logic [7:0]  out_phase_reg;

    logic        in_accept;
    logic        s1_adv;
    logic        out_free;
    logic        match;
    logic [14:0] knob_product;
    logic [14:0] rate_value;
    logic [7:0]  wave_value;

    assign out_free  = !out_valid_reg || out_ready;
    assign s1_adv    = s1_valid_reg && out_free;
    assign in_ready  = !s1_valid_reg || s1_adv;
    assign in_accept = in_valid && in_ready;
    assign match     = (tick_count_reg == compare_reg);

    assign knob_product = RATE_SLOPE * 15'(knob_level);
    assign rate_value   = RATE_BASE - knob_product;

    always_comb
    begin
        tick_count_next = tick_count_reg;
        phase_next      = phase_reg;
        compare_next    = compare_reg;
        if (in_accept)
        begin
            if (match)
            begin
                tick_count_next = '0;
                phase_next      = phase_reg + 8'd1;
            end
            else
            begin
                tick_count_next = tick_count_reg + count_t'(1);
            end
            if (knob_valid)
            begin
                compare_next = count_t'(rate_value);
            end
        end
    end

    // The triangle holds its previous level when the phase sits exactly on the peak.
    always_comb
    begin
        case (s1_choice_reg)
            WAVE_SAW:
            begin
                wave_value = s1_phase_reg;
            end
            WAVE_TRI:
            begin
                if (s1_phase_reg < TRI_PEAK)
                begin
                    wave_value = {s1_phase_reg[6:0], 1'b0};
                end
                else if (s1_phase_reg > TRI_PEAK)
                begin
                    wave_value = {~s1_phase_reg[6:0], 1'b0};
                end
                else
                begin
                    wave_value = level_hold_reg;
                end
            end
            default:
            begin
                wave_value = rom_data_reg;
            end
        endcase
    end

    always_comb
    begin
        level_hold_next = level_hold_reg;
        if (s1_adv && s1_stepped_reg)
        begin
            level_hold_next = wave_value;
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg <= '0;
            compare_reg    <= '0;
            phase_reg      <= '0;
            level_hold_reg <= '0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            tick_count_reg <= tick_count_next;
            compare_reg    <= compare_next;
            phase_reg      <= phase_next;
            level_hold_reg <= level_hold_next;
            s1_valid_reg   <= s1_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Sine ROM read at the new phase; the word waits with the middle stage under a stall.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            rom_data_reg   <= SINE_TABLE[phase_next];
            s1_stepped_reg <= match;
            s1_phase_reg   <= phase_next;
            s1_choice_reg  <= wave_code_t'(wave_choice);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_level_reg <= level_hold_next;
            out_step_reg  <= s1_stepped_reg;
            out_phase_reg <= s1_phase_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_level  = out_level_reg;
    assign phase_step = out_step_reg;
    assign phase_now  = out_phase_reg;

`ifndef NO_ASSERTIONS
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> (s1_valid_reg && $stable(s1_phase_reg)))
        else $error("middle stage lost or changed its word under a stall");

    a_step_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && match) |=> (tick_count_reg == '0))
        else $error("tick counter not cleared on a phase step");

    a_phase_inc: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && match) |=> (phase_reg == $past(phase_reg) + 8'd1))
        else $error("phase did not advance by one on a step");

    a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_accept && match) |=> $stable(phase_reg))
        else $error("phase changed without a step");

    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> in_ready)
        else $error("input blocked with an empty middle stage");
`endif

endmodule

`default_nettype wire
